// ----- rtl/bfp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants for the best-fit fragment packer.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int NumBinsDef   = 4;
  localparam int SlotsDef     = 14;
  localparam int IdBitsDef    = 8;
  localparam logic [11:0] DefaultCapacity = 12'd4064;
  localparam logic [3:0]  DefaultMaxSlots = 4'd14;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_FLUSH   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_CAPACITY  = 2'd0,
    CFG_MAX_SLOTS = 2'd1,
    CFG_ENABLE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRCH,
    ST_FALLBK,
    ST_PLACE,
    ST_POST,
    ST_RESORT,
    ST_FLUSH,
    ST_CL_RD,
    ST_CL_WR,
    ST_DR_START,
    ST_DR_RD,
    ST_DR_CHK,
    ST_DR_END,
    ST_EM_RD,
    ST_EM_OUT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  fragment_id;
    logic [11:0] fragment_size;
    logic [15:0] fragment_generation;
  } req_t;

  typedef struct packed {
    logic [7:0]  result_id;
    logic        packed_res;
    logic [15:0] block_number;
    logic [3:0]  slot_in_block;
    logic [11:0] byte_offset;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [11:0] size;
    logic [7:0]  id;
  } frag_t;

  typedef struct packed {
    logic push;
    logic fin;
  } rbuf_ctl_t;

endpackage

// ----- rtl/bfp_ram.sv -----
// ----------------------------------------------------------------------------
// bfp_ram
// Single write port, single registered read port storage array.
// ----------------------------------------------------------------------------
module bfp_ram #(
  parameter int Depth = 56,
  parameter int AddrW = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  bfp_pkg::frag_t       wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output bfp_pkg::frag_t       rdata_o
);

  bfp_pkg::frag_t mem [Depth];
  bfp_pkg::frag_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bfp_result_buf.sv -----
// ----------------------------------------------------------------------------
// bfp_result_buf
// One-deep hold stage that marks the final result of a transaction.
// ----------------------------------------------------------------------------
module bfp_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfp_pkg::rbuf_ctl_t ctl_i,
  input  bfp_pkg::res_t      res_i,
  output logic               result_valid_o,
  output bfp_pkg::res_t      result_o
);

  bfp_pkg::res_t hold_q, hold_d, out_q, out_d;
  logic          hold_v_q, hold_v_d, out_v_q, out_v_d;

  always_comb begin
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    out_v_d  = 1'b0;
    if (ctl_i.push) begin
      out_d      = hold_q;
      out_d.last = 1'b0;
      out_v_d    = hold_v_q;
      hold_d     = res_i;
      hold_v_d   = 1'b1;
    end else if (ctl_i.fin) begin
      out_d      = hold_q;
      out_d.last = 1'b1;
      out_v_d    = hold_v_q;
      hold_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign result_valid_o = out_v_q;
  assign result_o       = out_q;

endmodule

// ----- rtl/best_fit_fragment_packer_unit.sv -----
// ----------------------------------------------------------------------------
// best_fit_fragment_packer_unit
// Best-fit packer of fragments into blocks, driven by a small sequencer.
// ----------------------------------------------------------------------------
// channel    | handshake                 | payload
// request    | start, busy               | req_i
// result     | result_valid_o (strobe)   | result_o
// config     | cfg_we_i, cfg_idx_i       | cfg_wdata_i
//
// A transaction that places and queues nothing passes dispatch, drain start
// and finish. An add searches up to NUM_BINS ranked bins, takes a fallback
// step if none fits, then places, checks and re-ranks. Closing a bin reads
// and queues each fragment moved, and draining emits queued fragments in
// batches. Results are held one deep and leave when the next one is pushed;
// the last leaves in the same cycle busy falls. The receiver cannot stall
// them. Reset restores the state, configuration, bins and queue pointers.
// ----------------------------------------------------------------------------
module best_fit_fragment_packer_unit #(
  parameter int NUM_BINS = bfp_pkg::NumBinsDef,
  parameter int SLOTS    = bfp_pkg::SlotsDef,
  parameter int ID_BITS  = bfp_pkg::IdBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bfp_pkg::req_t req_i,
  output logic          result_valid_o,
  output bfp_pkg::res_t result_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [11:0]   cfg_wdata_i
);

  localparam int Depth = NUM_BINS * SLOTS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PtrW  = $clog2(Depth + 1);
  localparam int BinW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int FjW   = $clog2(NUM_BINS + 1);
  localparam logic [7:0] IdMask = (ID_BITS >= 8) ? 8'hFF : 8'((1 << ID_BITS) - 1);

  bfp_pkg::state_e state_q, state_d, ret_q, ret_d;
  logic [11:0]     cap_q, cap_d;
  logic [3:0]      maxs_q, maxs_d;
  logic            en_q, en_d;
  logic [11:0]     free_q [NUM_BINS];
  logic [11:0]     free_d [NUM_BINS];
  logic [3:0]      fill_q [NUM_BINS];
  logic [3:0]      fill_d [NUM_BINS];
  logic [BinW-1:0] rank_q [NUM_BINS];
  logic [BinW-1:0] rank_d [NUM_BINS];
  logic [15:0]     gen_q, gen_d, blk_q, blk_d;
  bfp_pkg::req_t   req_q, req_d;
  logic [BinW-1:0] i_q, i_d, b_q, b_d, cb_q, cb_d;
  logic [FjW-1:0]  fj_q, fj_d;
  logic [3:0]      cs_q, cs_d, k_q, k_d, slot_q, slot_d;
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, bs_q, bs_d, ep_q, ep_d;
  logic [11:0]     space_q, space_d, off_q, off_d;

  logic            bin_we, fifo_we;
  logic [AddrW-1:0] bin_wa, bin_ra, fifo_wa, fifo_ra;
  bfp_pkg::frag_t  bin_wd, bin_rd, fifo_wd, fifo_rd;
  bfp_pkg::rbuf_ctl_t rctl;
  bfp_pkg::res_t   rres;

  logic [3:0]      limit;
  logic [7:0]      id_m;
  logic [11:0]     ffree, used;
  logic [BinW-1:0] rest [NUM_BINS];
  logic [BinW-1:0] new_rank [NUM_BINS];
  logic [BinW:0]   m, j, pos;
  logic            found;

  assign busy = (state_q != bfp_pkg::ST_IDLE);
  assign id_m = req_q.fragment_id & IdMask;

  always_comb begin
    if (maxs_q > 4'(SLOTS)) begin
      limit = 4'(SLOTS);
    end else if (maxs_q == 4'd0) begin
      limit = 4'd1;
    end else begin
      limit = maxs_q;
    end
  end

  always_comb begin
    m     = '0;
    j     = '0;
    found = 1'b0;
    for (int n = 0; n < NUM_BINS; n++) begin
      rest[n]     = '0;
      new_rank[n] = '0;
    end
    for (int n = 0; n < NUM_BINS; n++) begin
      if (rank_q[n] != b_q) begin
        rest[m[BinW-1:0]] = rank_q[n];
        m = m + 1'b1;
      end
    end
    pos = m;
    for (int n = 0; n < NUM_BINS - 1; n++) begin
      if ((BinW + 1)'(n) < m && !found && free_q[rest[n]] > free_q[b_q]) begin
        pos   = (BinW + 1)'(n);
        found = 1'b1;
      end
    end
    for (int n = 0; n < NUM_BINS; n++) begin
      if ((BinW + 1)'(n) == pos) begin
        new_rank[n] = b_q;
      end else if (j < m) begin
        new_rank[n] = rest[j[BinW-1:0]];
        j = j + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cap_d   = cap_q;
    maxs_d  = maxs_q;
    en_d    = en_q;
    free_d  = free_q;
    fill_d  = fill_q;
    rank_d  = rank_q;
    gen_d   = gen_q;
    blk_d   = blk_q;
    req_d   = req_q;
    i_d     = i_q;
    b_d     = b_q;
    cb_d    = cb_q;
    fj_d    = fj_q;
    cs_d    = cs_q;
    k_d     = k_q;
    slot_d  = slot_q;
    wr_d    = wr_q;
    rd_d    = rd_q;
    bs_d    = bs_q;
    ep_d    = ep_q;
    space_d = space_q;
    off_d   = off_q;
    bin_we  = 1'b0;
    bin_wa  = '0;
    bin_wd  = '0;
    bin_ra  = '0;
    fifo_we = 1'b0;
    fifo_wa = wr_q[AddrW-1:0];
    fifo_wd = bin_rd;
    fifo_ra = '0;
    rctl    = '0;
    rres    = '0;
    ffree   = free_q[rank_q[0]];
    used    = (cap_q > ffree) ? (cap_q - ffree) : 12'd0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        bfp_pkg::CFG_CAPACITY:  cap_d  = cfg_wdata_i;
        bfp_pkg::CFG_MAX_SLOTS: maxs_d = cfg_wdata_i[3:0];
        bfp_pkg::CFG_ENABLE:    en_d   = cfg_wdata_i[0];
        default: ;
      endcase
    end

    case (state_q)
      bfp_pkg::ST_IDLE: begin
        if (start) begin
          req_d   = req_i;
          wr_d    = '0;
          rd_d    = '0;
          state_d = bfp_pkg::ST_DISPATCH;
        end
      end
      bfp_pkg::ST_DISPATCH: begin
        fj_d = '0;
        i_d  = '0;
        case (req_q.operation)
          bfp_pkg::OP_ADD: begin
            if (!en_q || req_q.fragment_generation < gen_q ||
                req_q.fragment_size >= cap_q) begin
              rctl.push      = 1'b1;
              rres.result_id = id_m;
              state_d        = bfp_pkg::ST_DR_START;
            end else begin
              state_d = bfp_pkg::ST_SRCH;
            end
          end
          bfp_pkg::OP_FLUSH: state_d = bfp_pkg::ST_FLUSH;
          bfp_pkg::OP_ADVANCE: begin
            gen_d   = gen_q + 16'd1;
            state_d = bfp_pkg::ST_FLUSH;
          end
          default: state_d = bfp_pkg::ST_DR_START;
        endcase
      end
      bfp_pkg::ST_SRCH: begin
        if (free_q[rank_q[i_q]] >= req_q.fragment_size) begin
          b_d     = rank_q[i_q];
          state_d = bfp_pkg::ST_PLACE;
        end else if (i_q == BinW'(NUM_BINS - 1)) begin
          state_d = bfp_pkg::ST_FALLBK;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      bfp_pkg::ST_FALLBK: begin
        if (req_q.fragment_size >= used) begin
          rctl.push      = 1'b1;
          rres.result_id = id_m;
          state_d        = bfp_pkg::ST_DR_START;
        end else begin
          b_d     = rank_q[0];
          state_d = bfp_pkg::ST_PLACE;
        end
      end
      bfp_pkg::ST_PLACE: begin
        if (free_q[b_q] < req_q.fragment_size || fill_q[b_q] >= 4'(SLOTS)) begin
          cb_d    = b_q;
          cs_d    = '0;
          ret_d   = bfp_pkg::ST_PLACE;
          state_d = bfp_pkg::ST_CL_RD;
        end else begin
          bin_we       = 1'b1;
          bin_wa       = AddrW'(b_q) * AddrW'(SLOTS) + AddrW'(fill_q[b_q]);
          bin_wd.size  = req_q.fragment_size;
          bin_wd.id    = id_m;
          fill_d[b_q]  = fill_q[b_q] + 4'd1;
          free_d[b_q]  = free_q[b_q] - req_q.fragment_size;
          state_d      = bfp_pkg::ST_POST;
        end
      end
      bfp_pkg::ST_POST: begin
        if (fill_q[b_q] >= limit || free_q[b_q] == 12'd0) begin
          cb_d    = b_q;
          cs_d    = '0;
          ret_d   = bfp_pkg::ST_RESORT;
          state_d = bfp_pkg::ST_CL_RD;
        end else begin
          state_d = bfp_pkg::ST_RESORT;
        end
      end
      bfp_pkg::ST_RESORT: begin
        rank_d  = new_rank;
        state_d = bfp_pkg::ST_DR_START;
      end
      bfp_pkg::ST_FLUSH: begin
        if (!en_q || fj_q == FjW'(NUM_BINS)) begin
          state_d = bfp_pkg::ST_DR_START;
        end else begin
          cb_d    = rank_q[fj_q[BinW-1:0]];
          fj_d    = fj_q + 1'b1;
          cs_d    = '0;
          ret_d   = bfp_pkg::ST_FLUSH;
          state_d = bfp_pkg::ST_CL_RD;
        end
      end
      bfp_pkg::ST_CL_RD: begin
        if (cs_q < fill_q[cb_q] && cs_q < 4'(SLOTS)) begin
          bin_ra  = AddrW'(cb_q) * AddrW'(SLOTS) + AddrW'(cs_q);
          state_d = bfp_pkg::ST_CL_WR;
        end else begin
          fill_d[cb_q] = '0;
          free_d[cb_q] = cap_q;
          state_d      = ret_q;
        end
      end
      bfp_pkg::ST_CL_WR: begin
        if (wr_q < PtrW'(Depth)) begin
          fifo_we = 1'b1;
          wr_d    = wr_q + 1'b1;
        end
        cs_d    = cs_q + 4'd1;
        state_d = bfp_pkg::ST_CL_RD;
      end
      bfp_pkg::ST_DR_START: begin
        bs_d    = rd_q;
        k_d     = '0;
        space_d = cap_q;
        state_d = (rd_q == wr_q) ? bfp_pkg::ST_FIN : bfp_pkg::ST_DR_RD;
      end
      bfp_pkg::ST_DR_RD: begin
        if (rd_q == wr_q || k_q == limit) begin
          state_d = bfp_pkg::ST_DR_END;
        end else begin
          fifo_ra = rd_q[AddrW-1:0];
          state_d = bfp_pkg::ST_DR_CHK;
        end
      end
      bfp_pkg::ST_DR_CHK: begin
        fifo_ra = rd_q[AddrW-1:0];
        if (fifo_rd.size <= space_q) begin
          space_d = space_q - fifo_rd.size;
          k_d     = k_q + 4'd1;
          rd_d    = rd_q + 1'b1;
          state_d = bfp_pkg::ST_DR_RD;
        end else begin
          state_d = bfp_pkg::ST_DR_END;
        end
      end
      bfp_pkg::ST_DR_END: begin
        if (k_q == 4'd0) begin
          rctl.push      = 1'b1;
          rres.result_id = fifo_rd.id;
          rd_d           = rd_q + 1'b1;
          state_d        = bfp_pkg::ST_DR_START;
        end else begin
          ep_d    = bs_q;
          slot_d  = '0;
          off_d   = '0;
          state_d = bfp_pkg::ST_EM_RD;
        end
      end
      bfp_pkg::ST_EM_RD: begin
        if (ep_q == rd_q) begin
          if (k_q >= 4'd2) begin
            blk_d = blk_q + 16'd1;
          end
          state_d = bfp_pkg::ST_DR_START;
        end else begin
          fifo_ra = ep_q[AddrW-1:0];
          state_d = bfp_pkg::ST_EM_OUT;
        end
      end
      bfp_pkg::ST_EM_OUT: begin
        rctl.push      = 1'b1;
        rres.result_id = fifo_rd.id;
        if (k_q >= 4'd2) begin
          rres.packed_res    = 1'b1;
          rres.block_number  = blk_q;
          rres.slot_in_block = slot_q;
          rres.byte_offset   = off_q;
        end
        off_d   = off_q + fifo_rd.size;
        slot_d  = slot_q + 4'd1;
        ep_d    = ep_q + 1'b1;
        state_d = bfp_pkg::ST_EM_RD;
      end
      bfp_pkg::ST_FIN: begin
        rctl.fin = 1'b1;
        state_d  = bfp_pkg::ST_IDLE;
      end
      default: state_d = bfp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfp_pkg::ST_IDLE;
      ret_q   <= bfp_pkg::ST_IDLE;
      cap_q   <= bfp_pkg::DefaultCapacity;
      maxs_q  <= bfp_pkg::DefaultMaxSlots;
      en_q    <= 1'b1;
      gen_q   <= '0;
      blk_q   <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      for (int n = 0; n < NUM_BINS; n++) begin
        free_q[n] <= bfp_pkg::DefaultCapacity;
        fill_q[n] <= '0;
        rank_q[n] <= BinW'(n);
      end
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cap_q   <= cap_d;
      maxs_q  <= maxs_d;
      en_q    <= en_d;
      gen_q   <= gen_d;
      blk_q   <= blk_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      free_q  <= free_d;
      fill_q  <= fill_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    i_q     <= i_d;
    b_q     <= b_d;
    cb_q    <= cb_d;
    fj_q    <= fj_d;
    cs_q    <= cs_d;
    k_q     <= k_d;
    slot_q  <= slot_d;
    bs_q    <= bs_d;
    ep_q    <= ep_d;
    space_q <= space_d;
    off_q   <= off_d;
  end

  bfp_ram #(.Depth(Depth), .AddrW(AddrW)) u_bin_store (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_wa),
    .wdata_i (bin_wd),
    .raddr_i (bin_ra),
    .rdata_o (bin_rd)
  );

  bfp_ram #(.Depth(Depth), .AddrW(AddrW)) u_pend_fifo (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_wa),
    .wdata_i (fifo_wd),
    .raddr_i (fifo_ra),
    .rdata_o (fifo_rd)
  );

  bfp_result_buf u_result_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (rctl),
    .res_i          (rres),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
